[sv/mlau_pkg.sv]
package mlau_pkg;

    // Fixed port width of every limb, operand and result word.
    localparam int WORD_W = 64;

    // Default limb width; the design supports 32 to 64.
    localparam int LIMB_BITS_DEF = 64;

    // Multiply runs one 32x32 partial product per step plus one step to drain.
    localparam int HALF_W    = 32;
    localparam int MUL_STEPS = 5;

    // Operation codes as they arrive on the input channel.
    typedef enum logic [1:0] {
        OP_ADD = 2'd0,
        OP_SUB = 2'd1,
        OP_MUL = 2'd2,
        OP_DIV = 2'd3
    } t_op;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic capture;   // take the accepted input transaction
        logic start;     // set up the multiply or divide unit
        logic mul_step;  // one partial-product step
        logic div_step;  // one quotient bit
        logic commit;    // load the output register and the running state
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        t_op  op;        // operation of the current run
        logic div_long;  // running remainder not below divisor: full-width divide
        logic b_zero;    // divisor is zero
        logic out_free;  // output register can take a result this cycle
    } t_dp_stat;

endpackage

[sv/mlau_ctrl.sv]
module mlau_ctrl
    import mlau_pkg::*;
#(
    parameter int LIMB_BITS = LIMB_BITS_DEF
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_ready,
    input  t_dp_stat i_stat,
    output t_dp_cmd  o_cmd
);

    localparam int CNT_W = $clog2(2 * LIMB_BITS + 1);

    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_START = 5'b00010,
        ST_MUL   = 5'b00100,
        ST_DIV   = 5'b01000,
        ST_HOLD  = 5'b10000
    } t_state;

    t_state           r_state, n_state;
    logic [CNT_W-1:0] r_cnt, n_cnt;

    assign o_in_ready = (r_state == ST_IDLE);

    // Next-state and command decode.
    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        o_cmd   = '0;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = ST_START;
                end
            end
            ST_START: begin
                o_cmd.start = 1'b1;
                unique case (i_stat.op)
                    OP_MUL: begin
                        n_cnt   = CNT_W'(MUL_STEPS);
                        n_state = ST_MUL;
                    end
                    OP_DIV: begin
                        if (i_stat.b_zero) begin
                            if (i_stat.out_free) begin
                                o_cmd.commit = 1'b1;
                                n_state      = ST_IDLE;
                            end else begin
                                n_state = ST_HOLD;
                            end
                        end else begin
                            n_cnt   = i_stat.div_long ? CNT_W'(2 * LIMB_BITS)
                                                      : CNT_W'(LIMB_BITS);
                            n_state = ST_DIV;
                        end
                    end
                    default: begin
                        // Add and subtract finish straight from the captured limbs.
                        if (i_stat.out_free) begin
                            o_cmd.commit = 1'b1;
                            n_state      = ST_IDLE;
                        end else begin
                            n_state = ST_HOLD;
                        end
                    end
                endcase
            end
            ST_MUL, ST_DIV: begin
                if (r_cnt == '0) begin
                    if (i_stat.out_free) begin
                        o_cmd.commit = 1'b1;
                        n_state      = ST_IDLE;
                    end else begin
                        n_state = ST_HOLD;
                    end
                end else begin
                    o_cmd.mul_step = (r_state == ST_MUL);
                    o_cmd.div_step = (r_state == ST_DIV);
                    n_cnt          = r_cnt - CNT_W'(1);
                end
            end
            ST_HOLD: begin
                if (i_stat.out_free) begin
                    o_cmd.commit = 1'b1;
                    n_state      = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // State and step counter.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

endmodule

[sv/mlau_dp.sv]
module mlau_dp
    import mlau_pkg::*;
#(
    parameter int LIMB_BITS = LIMB_BITS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic [1:0]        i_operation,
    input  logic [WORD_W-1:0] i_limb_a,
    input  logic [WORD_W-1:0] i_operand_b,
    input  logic              i_first_limb,
    input  logic              i_last_limb,
    input  logic              i_out_ready,
    output logic              o_out_valid,
    output logic [WORD_W-1:0] o_result_limb,
    output logic [WORD_W-1:0] o_final_word,
    output logic              o_end_of_run,
    output logic              o_divide_by_zero,
    input  t_dp_cmd           i_cmd,
    output t_dp_stat          o_stat
);

    localparam int L = LIMB_BITS;

    // Captured transaction.
    logic [L-1:0] r_a, r_b;
    logic         r_last;

    // Running state of the run.
    t_op          r_run_op;
    logic [L-1:0] r_run_word;
    logic         r_zds;

    // Multiply unit.
    logic [2*WORD_W-1:0] r_acc;
    logic [2*HALF_W-1:0] r_pp;
    logic [1:0]          r_ppos;
    logic [1:0]          r_msel;

    // Divide unit.
    logic [L-1:0]   r_rem, r_q;
    logic [2*L-1:0] r_dvd;

    // Output register.
    logic              r_out_valid;
    logic [WORD_W-1:0] r_res_out, r_fin_out;
    logic              r_eor_out, r_dbz_out;

    logic [WORD_W-1:0] w_a64, w_b64;
    logic [HALF_W-1:0] w_ah, w_bh;
    logic [L:0]        w_sum, w_diff, w_t, w_tsub;
    logic              w_ge;
    logic [L-1:0]      w_res, w_rw;
    logic              w_zds;

    assign o_stat.op       = r_run_op;
    assign o_stat.div_long = (r_run_word >= r_b);
    assign o_stat.b_zero   = (r_b == '0);
    assign o_stat.out_free = !r_out_valid || i_out_ready;

    // Partial-product operand halves.
    assign w_a64 = WORD_W'(r_a);
    assign w_b64 = WORD_W'(r_b);
    assign w_ah  = r_msel[0] ? w_a64[2*HALF_W-1:HALF_W] : w_a64[HALF_W-1:0];
    assign w_bh  = r_msel[1] ? w_b64[2*HALF_W-1:HALF_W] : w_b64[HALF_W-1:0];

    // One restoring-division bit: shift in the next dividend bit, try the divisor.
    assign w_t    = {r_rem, r_dvd[2*L-1]};
    assign w_ge   = (w_t >= {1'b0, r_b});
    assign w_tsub = w_t - {1'b0, r_b};

    // Carry and borrow chains over one limb.
    assign w_sum  = {1'b0, r_a} + {1'b0, r_b} + (L+1)'(r_run_word[0]);
    assign w_diff = {1'b0, r_a} - {1'b0, r_b} - (L+1)'(r_run_word[0]);

    // Result limb and next running state for the current operation.
    always_comb begin
        w_zds = r_zds;
        case (r_run_op)
            OP_ADD: begin
                w_res = w_sum[L-1:0];
                w_rw  = L'(w_sum[L]);
            end
            OP_SUB: begin
                w_res = w_diff[L-1:0];
                w_rw  = L'(w_diff[L]);
            end
            OP_MUL: begin
                w_res = r_acc[L-1:0];
                w_rw  = r_acc[2*L-1:L];
            end
            OP_DIV: begin
                if (r_b == '0) begin
                    w_res = '1;
                    w_rw  = '0;
                    w_zds = 1'b1;
                end else begin
                    w_res = r_q;
                    w_rw  = r_rem;
                end
            end
            default: begin
                w_res = w_sum[L-1:0];
                w_rw  = L'(w_sum[L]);
            end
        endcase
    end

    // Captured limbs.
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_a    <= i_limb_a[L-1:0];
            r_b    <= i_operand_b[L-1:0];
            r_last <= i_last_limb;
        end
    end

    // Run state: cleared by a first limb, advanced on commit.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run_op   <= OP_ADD;
            r_run_word <= '0;
            r_zds      <= 1'b0;
        end else if (i_cmd.capture && i_first_limb) begin
            r_run_op   <= t_op'(i_operation);
            r_run_word <= '0;
            r_zds      <= 1'b0;
        end else if (i_cmd.commit) begin
            r_run_word <= w_rw;
            r_zds      <= w_zds;
        end
    end

    // Multiply: accumulate the previous partial product, form the next one.
    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_acc  <= (2*WORD_W)'(r_run_word);
            r_pp   <= '0;
            r_ppos <= '0;
            r_msel <= '0;
        end else if (i_cmd.mul_step) begin
            r_acc  <= r_acc + ((2*WORD_W)'(r_pp) << (HALF_W * r_ppos));
            r_pp   <= w_ah * w_bh;
            r_ppos <= 2'(r_msel[0]) + 2'(r_msel[1]);
            r_msel <= r_msel + 2'd1;
        end
    end

    // Divide: a remainder below the divisor skips the upper dividend half.
    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_q <= '0;
            if (r_run_word >= r_b) begin
                r_rem <= '0;
                r_dvd <= {r_run_word, r_a};
            end else begin
                r_rem <= r_run_word;
                r_dvd <= {r_a, {L{1'b0}}};
            end
        end else if (i_cmd.div_step) begin
            r_rem <= w_ge ? w_tsub[L-1:0] : w_t[L-1:0];
            r_q   <= {r_q[L-2:0], w_ge};
            r_dvd <= {r_dvd[2*L-2:0], 1'b0};
        end
    end

    // Output register valid flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.commit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // Output payload.
    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            r_res_out <= WORD_W'(w_res);
            r_fin_out <= r_last ? WORD_W'(w_rw) : '0;
            r_eor_out <= r_last;
            r_dbz_out <= (r_run_op == OP_DIV) && w_zds;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_result_limb    = r_res_out;
    assign o_final_word     = r_fin_out;
    assign o_end_of_run     = r_eor_out;
    assign o_divide_by_zero = r_dbz_out;

endmodule

[sv/multiword_limb_arithmetic_unit.sv]
// Channel   Direction  Handshake                   Payload
// input     in         i_in_valid / o_in_ready     i_operation, i_limb_a, i_operand_b,
//                                                  i_first_limb, i_last_limb
// result    out        o_out_valid / i_out_ready   o_result_limb, o_final_word,
//                                                  o_end_of_run, o_divide_by_zero
//
// One limb is in flight at a time. Add and subtract commit straight from the captured
// limbs; multiply runs four 32x32 partial products and one drain step. Divide runs the
// one-bit-per-cycle restoring divider on the running remainder and the limb, and skips
// the upper dividend half when the running remainder is below the divisor.
// A zero divisor skips the divider. Reset is synchronous and clears the run state.
// A waiting result does not block the next accept; a full output register only
// holds the finished limb until the result transaction completes.
module multiword_limb_arithmetic_unit
    import mlau_pkg::*;
#(
    parameter int LIMB_BITS = LIMB_BITS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  logic [1:0]        i_operation,
    input  logic [WORD_W-1:0] i_limb_a,
    input  logic [WORD_W-1:0] i_operand_b,
    input  logic              i_first_limb,
    input  logic              i_last_limb,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output logic [WORD_W-1:0] o_result_limb,
    output logic [WORD_W-1:0] o_final_word,
    output logic              o_end_of_run,
    output logic              o_divide_by_zero
);

    t_dp_cmd  w_cmd;
    t_dp_stat w_stat;

    // Sequencer.
    mlau_ctrl #(
        .LIMB_BITS(LIMB_BITS)
    ) u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in_valid(i_in_valid),
        .o_in_ready(o_in_ready),
        .i_stat    (w_stat),
        .o_cmd     (w_cmd)
    );

    // Arithmetic units, run state and output register.
    mlau_dp #(
        .LIMB_BITS(LIMB_BITS)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_operation     (i_operation),
        .i_limb_a        (i_limb_a),
        .i_operand_b     (i_operand_b),
        .i_first_limb    (i_first_limb),
        .i_last_limb     (i_last_limb),
        .i_out_ready     (i_out_ready),
        .o_out_valid     (o_out_valid),
        .o_result_limb   (o_result_limb),
        .o_final_word    (o_final_word),
        .o_end_of_run    (o_end_of_run),
        .o_divide_by_zero(o_divide_by_zero),
        .i_cmd           (w_cmd),
        .o_stat          (w_stat)
    );

    // A result is only loaded when the output register can take it.
    a_commit_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.commit |-> w_stat.out_free)
        else $error("result loaded over an untaken result");

    // An accepted transaction closes the input until its result is committed.
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("input reopened before the limb finished");

    // Output valid only rises after a commit.
    a_valid_from_commit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(w_cmd.commit))
        else $error("output valid without a committed result");

    // Capture and commit never coincide.
    a_capture_commit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_cmd.capture && w_cmd.commit))
        else $error("capture and commit in the same cycle");

endmodule
